// ===== rtl/csvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvrs_pkg
// Types and constants shared by the CSV record/field scanner modules.
// ----------------------------------------------------------------------------
package csvrs_pkg;

  localparam int unsigned FieldIdxW = 8;
  localparam int unsigned LengthBits = 24;
  localparam int unsigned ClassW = 3;

  localparam logic [FieldIdxW-1:0] FieldCountMax = 8'd255;
  localparam logic [LengthBits-1:0] LengthCap = {LengthBits{1'b1}};

  // Characters of interest
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;

  // Byte classes
  localparam logic [ClassW-1:0] ClsContent = 3'd0;
  localparam logic [ClassW-1:0] ClsSep = 3'd1;
  localparam logic [ClassW-1:0] ClsTerm = 3'd2;
  localparam logic [ClassW-1:0] ClsCrlfLf = 3'd3;
  localparam logic [ClassW-1:0] ClsOpenQ = 3'd4;
  localparam logic [ClassW-1:0] ClsQuotedQ = 3'd5;
  localparam logic [ClassW-1:0] ClsDoubleQ = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [ClassW-1:0]     byte_class;
    logic [FieldIdxW-1:0]  field_index;
    logic [LengthBits-1:0] record_length;
    logic                  record_done;
  } out_item_t;

endpackage

// ===== rtl/csvrs_in_stage.sv =====
// ----------------------------------------------------------------------------
// csvrs_in_stage
// Input register: holds one accepted byte until the scan core consumes it.
// ----------------------------------------------------------------------------
module csvrs_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csvrs_pkg::in_item_t  in_item_i,
  input  logic                 advance_i,
  output logic                 stage_valid_o,
  output csvrs_pkg::in_item_t  stage_item_o
);

  logic                valid_q;
  logic                valid_d;
  csvrs_pkg::in_item_t item_q;
  logic                accept;

  // Room when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o = item_q;

endmodule

// ===== rtl/csvrs_scan_core.sv =====
// ----------------------------------------------------------------------------
// csvrs_scan_core
// Scanner state (quote/CR flags, field and length counters) and the
// combinational classification of one byte.
// ----------------------------------------------------------------------------
module csvrs_scan_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  csvrs_pkg::in_item_t  item_i,
  output csvrs_pkg::out_item_t result_o
);

  logic                               in_quotes_q, in_quotes_d;
  logic                               field_start_q, field_start_d;
  logic                               quote_pend_q, quote_pend_d;
  logic                               cr_pend_q, cr_pend_d;
  logic [csvrs_pkg::FieldIdxW-1:0]    field_cnt_q, field_cnt_d;
  logic [csvrs_pkg::LengthBits-1:0]   length_cnt_q, length_cnt_d;

  logic                               cr_hit;
  logic                               fresh;
  logic                               dq_hit;
  logic                               iq_e;
  logic                               fs_e;
  logic                               qp_e;
  logic [csvrs_pkg::FieldIdxW-1:0]    fc_e;
  logic [csvrs_pkg::LengthBits-1:0]   lc_e;
  logic [csvrs_pkg::LengthBits-1:0]   len;
  logic [csvrs_pkg::ClassW-1:0]       cls;
  logic                               done;
  logic                               end_rec;
  logic [7:0]                         b;

  assign b = item_i.data_byte;

  always_comb begin
    // A pending CR followed by anything but LF starts a fresh record
    cr_hit = cr_pend_q && (b == csvrs_pkg::ChLf);
    fresh = cr_pend_q && !cr_hit;
    iq_e = fresh ? 1'b0 : in_quotes_q;
    fs_e = fresh ? 1'b1 : field_start_q;
    qp_e = fresh ? 1'b0 : quote_pend_q;
    fc_e = fresh ? '0 : field_cnt_q;
    lc_e = fresh ? '0 : length_cnt_q;

    dq_hit = !cr_hit && qp_e && (b == csvrs_pkg::ChQuote);
    // Pending quote not doubled: it closed the quoted field
    if (!cr_hit && qp_e && !dq_hit) begin
      iq_e = 1'b0;
    end

    // Every byte adds one to the length, saturating at LengthCap
    len = (lc_e == csvrs_pkg::LengthCap) ? lc_e : lc_e + 1'b1;

    in_quotes_d = iq_e;
    field_start_d = fs_e;
    quote_pend_d = 1'b0;
    cr_pend_d = 1'b0;
    field_cnt_d = fc_e;
    length_cnt_d = len;
    cls = csvrs_pkg::ClsContent;
    done = 1'b0;
    end_rec = 1'b0;

    if (cr_hit) begin
      cls = csvrs_pkg::ClsCrlfLf;
      done = 1'b1;
      end_rec = 1'b1;
    end else if (dq_hit) begin
      cls = csvrs_pkg::ClsDoubleQ;
    end else if (iq_e) begin
      if (b == csvrs_pkg::ChQuote) begin
        cls = csvrs_pkg::ClsQuotedQ;
        quote_pend_d = 1'b1;
      end
    end else if (b == csvrs_pkg::ChLf) begin
      cls = csvrs_pkg::ClsTerm;
      done = 1'b1;
      end_rec = 1'b1;
    end else if (b == csvrs_pkg::ChCr) begin
      cls = csvrs_pkg::ClsTerm;
      done = 1'b1;
      cr_pend_d = 1'b1;
    end else if (b == csvrs_pkg::ChComma) begin
      cls = csvrs_pkg::ClsSep;
      if (fc_e < csvrs_pkg::FieldCountMax) begin
        field_cnt_d = fc_e + 1'b1;
      end
      field_start_d = 1'b1;
    end else if ((b == csvrs_pkg::ChQuote) && fs_e) begin
      cls = csvrs_pkg::ClsOpenQ;
      in_quotes_d = 1'b1;
      field_start_d = 1'b0;
    end else begin
      field_start_d = 1'b0;
    end

    if (end_rec || item_i.stream_end) begin
      in_quotes_d = 1'b0;
      field_start_d = 1'b1;
      quote_pend_d = 1'b0;
      cr_pend_d = 1'b0;
      field_cnt_d = '0;
      length_cnt_d = '0;
    end

    result_o.byte_class = cls;
    result_o.field_index = fc_e;
    result_o.record_length = len;
    result_o.record_done = done || item_i.stream_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q <= 1'b0;
      field_start_q <= 1'b1;
      quote_pend_q <= 1'b0;
      cr_pend_q <= 1'b0;
      field_cnt_q <= '0;
      length_cnt_q <= '0;
    end else if (advance_i) begin
      in_quotes_q <= in_quotes_d;
      field_start_q <= field_start_d;
      quote_pend_q <= quote_pend_d;
      cr_pend_q <= cr_pend_d;
      field_cnt_q <= field_cnt_d;
      length_cnt_q <= length_cnt_d;
    end
  end

endmodule

// ===== rtl/csvrs_out_stage.sv =====
// ----------------------------------------------------------------------------
// csvrs_out_stage
// Result register: holds one classified byte until the sink takes it.
// ----------------------------------------------------------------------------
module csvrs_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  csvrs_pkg::out_item_t result_i,
  output logic                 load_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output csvrs_pkg::out_item_t out_item_o
);

  logic                 valid_q;
  logic                 valid_d;
  csvrs_pkg::out_item_t item_q;

  assign load_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o = item_q;

endmodule

// ===== rtl/csv_record_field_scanner.sv =====
// ----------------------------------------------------------------------------
// csv_record_field_scanner
// Classifies a CSV byte stream and tracks field index and record length.
// ----------------------------------------------------------------------------
// One byte per transaction, one result per byte. A byte passes through the input
// register, then the result register, and a new byte can be taken every cycle
// while the result side does not stall: the quote/CR flags and the field and
// length counters update in the same cycle a byte moves from the input
// register to the result register. Backpressure on the result side stalls
// that move and, through it, the input.
module csv_record_field_scanner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csvrs_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output csvrs_pkg::out_item_t out_item_o
);

  logic                 stage_valid;
  csvrs_pkg::in_item_t  stage_item;
  logic                 load_ready;
  logic                 advance;
  csvrs_pkg::out_item_t result;

  assign advance = stage_valid && load_ready;

  csvrs_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  csvrs_scan_core u_scan_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .result_o  (result)
  );

  csvrs_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .result_i     (result),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // Terminators always close the record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.byte_class == csvrs_pkg::ClsTerm) ||
                    (out_item_o.byte_class == csvrs_pkg::ClsCrlfLf))
    |-> out_item_o.record_done)
    else $error("terminator without record_done");

  // Every result counts at least the byte itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.record_length != '0))
    else $error("zero record length");

  // Held byte plus stalled result leaves no room for input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline is full");

  // An accepted byte is in the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stage_valid)
    else $error("accepted byte lost");

endmodule

// ===== verif/csv_record_field_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// csv_record_field_scanner_tb
// Self-checking testbench for the CSV record/field scanner. A directed run
// covers quoting, doubled quotes, CR/LF handling and stream end. Random CSV
// records and raw noise follow. Both handshakes idle in random bursts. Each
// result is checked against a byte-level model of the scanner.
// ----------------------------------------------------------------------------
module csv_record_field_scanner_tb;

  // Byte-level model of the scanner plus the queue of expected results.
  class csv_scan_scoreboard;
    csvrs_pkg::out_item_t                 expected_scans[$];
    int                                   errors;
    logic                                 quoted;
    logic                                 field_start;
    logic                                 quote_seen;
    logic                                 cr_seen;
    logic [csvrs_pkg::FieldIdxW-1:0]      field_cnt;
    logic [csvrs_pkg::LengthBits-1:0]     rec_len;

    function new();
      errors = 0;
      clear_record();
    endfunction

    function void clear_record();
      quoted      = 1'b0;
      field_start = 1'b1;
      quote_seen  = 1'b0;
      cr_seen     = 1'b0;
      field_cnt   = '0;
      rec_len     = '0;
    endfunction

    function void bump_len();
      if (rec_len != csvrs_pkg::LengthCap) rec_len++;
    endfunction

    function int outstanding();
      return expected_scans.size();
    endfunction

    function void note_byte(csvrs_pkg::in_item_t it);
      csvrs_pkg::out_item_t res;
      logic [7:0]           b;
      logic                 handled;
      logic                 ends_record;
      b           = it.data_byte;
      res         = '0;
      res.byte_class = csvrs_pkg::ClsContent;
      handled     = 1'b0;
      ends_record = 1'b0;

      // a CR was the terminator; LF right after it belongs to the same record
      if (cr_seen) begin
        cr_seen = 1'b0;
        if (b == csvrs_pkg::ChLf) begin
          bump_len();
          res.byte_class  = csvrs_pkg::ClsCrlfLf;
          res.record_done = 1'b1;
          ends_record     = 1'b1;
          handled         = 1'b1;
        end else begin
          clear_record();
        end
      end

      // quote inside quotes: doubled pair or closing quote, decided here
      if (!handled && quote_seen) begin
        quote_seen = 1'b0;
        if (b == csvrs_pkg::ChQuote) begin
          bump_len();
          res.byte_class = csvrs_pkg::ClsDoubleQ;
          handled        = 1'b1;
        end else begin
          quoted = 1'b0;
        end
      end

      res.field_index = field_cnt;

      if (!handled) begin
        bump_len();
        if (quoted) begin
          if (b == csvrs_pkg::ChQuote) begin
            res.byte_class = csvrs_pkg::ClsQuotedQ;
            quote_seen     = 1'b1;
          end
        end else if (b == csvrs_pkg::ChLf) begin
          res.byte_class  = csvrs_pkg::ClsTerm;
          res.record_done = 1'b1;
          ends_record     = 1'b1;
        end else if (b == csvrs_pkg::ChCr) begin
          res.byte_class  = csvrs_pkg::ClsTerm;
          res.record_done = 1'b1;
          cr_seen         = 1'b1;
        end else if (b == csvrs_pkg::ChComma) begin
          res.byte_class = csvrs_pkg::ClsSep;
          if (field_cnt != csvrs_pkg::FieldCountMax) field_cnt++;
          field_start = 1'b1;
        end else if (b == csvrs_pkg::ChQuote && field_start) begin
          res.byte_class = csvrs_pkg::ClsOpenQ;
          quoted         = 1'b1;
          field_start    = 1'b0;
        end else begin
          field_start = 1'b0;
        end
      end

      res.record_length = rec_len;
      if (it.stream_end) res.record_done = 1'b1;
      expected_scans.push_back(res);
      if (ends_record || it.stream_end) clear_record();
    endfunction

    function void check_result(csvrs_pkg::out_item_t got);
      csvrs_pkg::out_item_t exp;
      if (expected_scans.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cls=%0d idx=%0d len=%0d done=%0b", $time,
                 got.byte_class, got.field_index, got.record_length, got.record_done);
        return;
      end
      exp = expected_scans.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch expected cls=%0d idx=%0d len=%0d done=%0b", $time,
                 exp.byte_class, exp.field_index, exp.record_length, exp.record_done);
        $display("%0t:          actual   cls=%0d idx=%0d len=%0d done=%0b", $time,
                 got.byte_class, got.field_index, got.record_length, got.record_done);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  csvrs_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_ready;
  csvrs_pkg::out_item_t out_item;

  csv_scan_scoreboard sb;
  bit quiet;
  int sent;

  csv_record_field_scanner u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(csvrs_pkg::in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic void add_byte(ref csvrs_pkg::in_item_t q[$], input logic [7:0] b);
    csvrs_pkg::in_item_t it;
    it.data_byte  = b;
    it.stream_end = 1'b0;
    q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_text(bit in_quoted);
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (in_quoted && r == 0) return csvrs_pkg::ChComma;
    if (in_quoted && r == 1) return $urandom_range(0, 1) ? csvrs_pkg::ChCr : csvrs_pkg::ChLf;
    c = 8'($urandom_range(8'h20, 8'h7e));
    if (c == csvrs_pkg::ChQuote || c == csvrs_pkg::ChComma) c = 8'h5f;
    return c;
  endfunction

  function automatic void build_record(ref csvrs_pkg::in_item_t q[$], input int nfields);
    int kind;
    int n;
    int term;
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) add_byte(q, csvrs_pkg::ChComma);
      kind = $urandom_range(0, 9);
      if (nfields > 50 && $urandom_range(0, 7) != 0) kind = 3;
      if (kind < 3) begin
        add_byte(q, csvrs_pkg::ChQuote);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            add_byte(q, csvrs_pkg::ChQuote);
            add_byte(q, csvrs_pkg::ChQuote);
          end else begin
            add_byte(q, pick_text(1'b1));
          end
        end
        add_byte(q, csvrs_pkg::ChQuote);
        // stray byte after the closing quote
        if ($urandom_range(0, 9) == 0) add_byte(q, pick_text(1'b0));
      end else if (kind != 3) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_byte(q, pick_text(1'b0));
          if (i == 0 && $urandom_range(0, 7) == 0) add_byte(q, csvrs_pkg::ChQuote);
        end
      end
    end
    term = $urandom_range(0, 3);
    if (term == 0) begin
      add_byte(q, csvrs_pkg::ChLf);
    end else if (term == 2) begin
      add_byte(q, csvrs_pkg::ChCr);
    end else begin
      add_byte(q, csvrs_pkg::ChCr);
      add_byte(q, csvrs_pkg::ChLf);
    end
    if ($urandom_range(0, 7) == 0) q[q.size()-1].stream_end = 1'b1;
    if ($urandom_range(0, 19) == 0) q[$urandom_range(0, q.size()-1)].stream_end = 1'b1;
  endfunction

  function automatic void build_noise(ref csvrs_pkg::in_item_t q[$]);
    int n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: add_byte(q, csvrs_pkg::ChQuote);
        1: add_byte(q, csvrs_pkg::ChComma);
        2: add_byte(q, csvrs_pkg::ChCr);
        3: add_byte(q, csvrs_pkg::ChLf);
        default: add_byte(q, 8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 29) == 0) q[q.size()-1].stream_end = 1'b1;
    end
  endfunction

  // stimulus
  initial begin
    csvrs_pkg::in_item_t directed[$];
    int                  rec_no;
    bit                  paused;
    sb       = new();
    quiet    = 1'b0;
    sent     = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_byte(directed, 8'h61);    // content
    add_byte(directed, csvrs_pkg::ChComma);
    add_byte(directed, csvrs_pkg::ChQuote);  // opens quoting
    add_byte(directed, 8'h78);
    add_byte(directed, csvrs_pkg::ChQuote);  // doubled pair
    add_byte(directed, csvrs_pkg::ChQuote);
    add_byte(directed, csvrs_pkg::ChComma);  // comma inside quotes
    add_byte(directed, csvrs_pkg::ChQuote);  // closing quote, resolved by the CR
    add_byte(directed, csvrs_pkg::ChCr);
    add_byte(directed, csvrs_pkg::ChLf);     // completes CR LF
    add_byte(directed, 8'h62);
    add_byte(directed, csvrs_pkg::ChQuote);  // quote not at field start
    add_byte(directed, csvrs_pkg::ChCr);
    add_byte(directed, 8'hff);    // CR followed by other byte
    add_byte(directed, 8'h00);
    add_byte(directed, csvrs_pkg::ChLf);
    add_byte(directed, csvrs_pkg::ChQuote);
    add_byte(directed, csvrs_pkg::ChQuote);  // stream end with a quote pending
    directed[directed.size()-1].stream_end = 1'b1;
    add_byte(directed, csvrs_pkg::ChQuote);
    add_byte(directed, csvrs_pkg::ChCr);     // stream end inside an open quoted field
    directed[directed.size()-1].stream_end = 1'b1;
    add_byte(directed, csvrs_pkg::ChLf);
    add_byte(directed, 8'h80);
    directed[directed.size()-1].stream_end = 1'b1;
    foreach (directed[i]) send_byte(directed[i]);

    in_valid <= 1'b0;
    drain_results();

    rec_no = 0;
    paused = 1'b0;
    while (sent < 750) begin
      csvrs_pkg::in_item_t rec_q[$];
      rec_q.delete();
      if (rec_no == 5) begin
        build_record(rec_q, 300);   // drives the field index into saturation
      end else if ($urandom_range(0, 9) < 2) begin
        build_noise(rec_q);
      end else begin
        build_record(rec_q, $urandom_range(1, 6));
      end
      rec_no++;
      foreach (rec_q[i]) begin
        if (sent >= 650) quiet = 1'b1;
        send_byte(rec_q[i]);
      end
      if (!paused && sent >= 350) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results();
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("csv_record_field_scanner_tb OK");
    end else begin
      $display("csv_record_field_scanner_tb NOT OK");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !quiet) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = 0;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  initial begin
    #8000000;
    $display("csv_record_field_scanner_tb NOT OK");
    $finish;
  end

endmodule
